/* rtl/rlu_pkg.sv */
// ----------------------------------------------------------------------------
// rlu_pkg: shared types and codes of the regression loss unit
// Register indexes, loss and reduction codes, and the sequencer states.
// ----------------------------------------------------------------------------
package rlu_pkg;

	localparam logic [2:0] REG_LOSS_KIND     = 3'd0;
	localparam logic [2:0] REG_DIRECTION     = 3'd1;
	localparam logic [2:0] REG_REDUCTION     = 3'd2;
	localparam logic [2:0] REG_DELTA         = 3'd3;
	localparam logic [2:0] REG_ELEMENT_COUNT = 3'd4;

	localparam logic [1:0] LOSS_MSE    = 2'd0;
	localparam logic [1:0] LOSS_L1     = 2'd1;
	localparam logic [1:0] LOSS_SMOOTH = 2'd2;
	localparam logic [1:0] LOSS_HUBER  = 2'd3;

	localparam logic [1:0] RED_NONE = 2'd0;
	localparam logic [1:0] RED_MEAN = 2'd1;
	localparam logic [1:0] RED_SUM  = 2'd2;
	localparam logic [1:0] RED_ALT  = 2'd3;

	// Prediction and target are signed Q8.8.
	localparam int DATA_W = 16;
	localparam int OUT_W  = 48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_POST,
		ST_OUT
	} state_t;

endpackage

/* rtl/regression_loss_unit_top.sv */
// ----------------------------------------------------------------------------
// regression_loss_unit_top: MSE, L1, smooth L1 and Huber loss and gradient
// One word at a time; a shared multiplier and a radix-2 divider do the work.
// ----------------------------------------------------------------------------
// Steps: accept, ST_MUL, ST_PREP, ST_POST and ST_OUT, with a pass of the shared
// 48-step divider after ST_PREP (smooth L1 below delta) or after ST_POST (mean
// gradient, mean total), so both for a smooth L1 gradient below delta under mean.
// The next word is accepted only once the previous one is back in ST_IDLE, which
// follows ST_POST when a word only adds to the sum; a result may wait in the output
// register while the next word runs. Reset clears the sum and loads defaults.
module regression_loss_unit_top #(
	parameter int MAX_ELEMENTS = 65536
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [2:0]                         cfg_index,
	input  logic [31:0]                        cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [rlu_pkg::DATA_W-1:0]  prediction,
	input  logic signed [rlu_pkg::DATA_W-1:0]  target,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [rlu_pkg::OUT_W-1:0]   value,
	output logic                               is_total
);
	localparam int DW = rlu_pkg::DATA_W;
	localparam int OW = rlu_pkg::OUT_W;
	localparam int AW = DW + 1;
	localparam int PW = 2 * AW;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int NW = OW;
	localparam int RW = 17;
	localparam int IW = $clog2(NW);
	localparam logic [OW-1:0] OMAX = {1'b0, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] ONE  = OW'(65536);

	logic [1:0]  kind_q;
	logic        dir_q;
	logic [1:0]  red_q;
	logic [15:0] delta_q;
	logic [16:0] count_q;

	rlu_pkg::state_t st_q, st_d, ret_q;

	logic [AW-1:0]        a_q;
	logic                 neg_q;
	logic [PW-1:0]        prod_q;
	logic [NW-1:0]        num_q;
	logic [RW-1:0]        den_q, rem_q;
	logic [IW-1:0]        it_q;
	logic [OW-1:0]        res_q;
	logic                 tot_q;
	logic [OW-1:0]        acc_q;
	logic [CW-1:0]        seen_q;
	logic                 ov_q;
	logic signed [OW-1:0] val_q;
	logic                 tot_out_q;

	logic is_mean;
	assign is_mean = (red_q == rlu_pkg::RED_MEAN) || (red_q == rlu_pkg::RED_ALT);

	logic [CW-1:0] cnt;
	always_comb begin
		if (count_q == 17'd0) cnt = CW'(1);
		else if ({15'd0, count_q} > 32'(MAX_ELEMENTS)) cnt = CW'(MAX_ELEMENTS);
		else cnt = CW'(count_q);
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (st_q != rlu_pkg::ST_IDLE);
	assign out_valid = ov_q;
	assign value     = val_q;
	assign is_total  = tot_out_q;

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	logic signed [AW-1:0] dif;
	assign dif = AW'(prediction) - AW'(target);

	logic below;
	assign below = a_q < AW'(delta_q);

	// Shared multiplier: a*a, or for Huber at or above delta D*(2a - D) = 2Da - D*D.
	logic          huber_hi;
	logic [AW-1:0] mul_x, mul_y;
	logic [PW-1:0] mul_res;
	assign huber_hi = (kind_q == rlu_pkg::LOSS_HUBER) && !below;
	assign mul_x    = huber_hi ? AW'(delta_q) : a_q;
	assign mul_y    = huber_hi ? ((a_q << 1) - AW'(delta_q)) : a_q;
	assign mul_res  = PW'(mul_x) * PW'(mul_y);

	// Preparation chooses the value and whether a division by delta (or 2*delta) follows.
	logic [OW-1:0] pre_val;
	logic [RW-1:0] pre_den;
	logic          pre_div;
	always_comb begin
		pre_val = '0;
		pre_den = RW'(delta_q);
		pre_div = 1'b0;
		if (dir_q) begin
			case (kind_q)
				rlu_pkg::LOSS_MSE: pre_val = OW'(a_q) << 9;
				rlu_pkg::LOSS_L1:  pre_val = (a_q != '0) ? ONE : '0;
				rlu_pkg::LOSS_SMOOTH: begin
					if (below) begin
						pre_val = OW'(a_q) << 16;
						pre_div = 1'b1;
					end else pre_val = (a_q != '0) ? ONE : '0;
				end
				default: begin
					if (below) pre_val = OW'(a_q) << 8;
					else if (a_q != '0) pre_val = OW'(delta_q) << 8;
				end
			endcase
		end else begin
			case (kind_q)
				rlu_pkg::LOSS_MSE: pre_val = OW'(prod_q);
				rlu_pkg::LOSS_L1:  pre_val = OW'(a_q) << 8;
				rlu_pkg::LOSS_SMOOTH: begin
					if (below) begin
						pre_val = OW'(prod_q) << 8;
						pre_den = {delta_q, 1'b0};
						pre_div = 1'b1;
					end else pre_val = (OW'(a_q) << 8) - (OW'(delta_q) << 7);
				end
				default: pre_val = OW'(prod_q >> 1);
			endcase
		end
	end

	// One restoring division step.
	logic [RW:0]   rem_sh;
	logic [RW-1:0] rem_n;
	logic          qbit;
	always_comb begin
		rem_sh = {rem_q, num_q[NW-1]};
		qbit   = rem_sh >= {1'b0, den_q};
		rem_n  = qbit ? RW'(rem_sh - {1'b0, den_q}) : rem_sh[RW-1:0];
	end

	logic [NW-1:0] quo_n;
	logic          div_last;
	assign quo_n    = {num_q[NW-2:0], qbit};
	assign div_last = (it_q == IW'(NW - 1));

	// Accumulator add with saturation.
	logic [OW:0]   acc_sum;
	logic [OW-1:0] sum_sat;
	logic [CW:0]   seen_n;
	logic          acc_on, last_elem, post_div, out_load;
	assign acc_sum   = {1'b0, acc_q} + {1'b0, res_q};
	assign sum_sat   = (acc_sum > {1'b0, OMAX}) ? OMAX : acc_sum[OW-1:0];
	assign seen_n    = {1'b0, seen_q} + (CW+1)'(1);
	assign acc_on    = !dir_q && (red_q != rlu_pkg::RED_NONE);
	assign last_elem = seen_n >= {1'b0, cnt};
	assign post_div  = is_mean && (dir_q || (acc_on && last_elem));
	assign out_load  = (st_q == rlu_pkg::ST_OUT) && (!ov_q || !out_stall);

	always_comb begin
		st_d = st_q;
		case (st_q)
			rlu_pkg::ST_IDLE: if (in_acc) st_d = rlu_pkg::ST_MUL;
			rlu_pkg::ST_MUL:  st_d = rlu_pkg::ST_PREP;
			rlu_pkg::ST_PREP: st_d = pre_div ? rlu_pkg::ST_DIV : rlu_pkg::ST_POST;
			rlu_pkg::ST_DIV:  if (div_last) st_d = ret_q;
			rlu_pkg::ST_POST: begin
				if (post_div) st_d = rlu_pkg::ST_DIV;
				else if (acc_on && !last_elem) st_d = rlu_pkg::ST_IDLE;
				else st_d = rlu_pkg::ST_OUT;
			end
			rlu_pkg::ST_OUT:  if (out_load) st_d = rlu_pkg::ST_IDLE;
			default:          st_d = rlu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= rlu_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= rlu_pkg::LOSS_MSE;
			dir_q     <= 1'b0;
			red_q     <= rlu_pkg::RED_MEAN;
			delta_q   <= 16'd256;
			count_q   <= 17'd1;
			ret_q     <= rlu_pkg::ST_POST;
			a_q       <= '0;
			neg_q     <= 1'b0;
			prod_q    <= '0;
			num_q     <= '0;
			den_q     <= '0;
			rem_q     <= '0;
			it_q      <= '0;
			res_q     <= '0;
			tot_q     <= 1'b0;
			acc_q     <= '0;
			seen_q    <= '0;
			ov_q      <= 1'b0;
			val_q     <= '0;
			tot_out_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rlu_pkg::REG_LOSS_KIND:     kind_q  <= cfg_data[1:0];
					rlu_pkg::REG_DIRECTION:     dir_q   <= cfg_data[0];
					rlu_pkg::REG_REDUCTION:     red_q   <= cfg_data[1:0];
					rlu_pkg::REG_DELTA:         delta_q <= cfg_data[15:0];
					rlu_pkg::REG_ELEMENT_COUNT: count_q <= cfg_data[16:0];
					default: ;
				endcase
			end
			if (out_load) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			case (st_q)
				rlu_pkg::ST_IDLE: if (in_acc) begin
					neg_q <= dif[AW-1];
					a_q   <= dif[AW-1] ? AW'(-dif) : AW'(dif);
				end
				rlu_pkg::ST_MUL: prod_q <= mul_res;
				rlu_pkg::ST_PREP: begin
					res_q <= pre_val;
					num_q <= pre_val;
					den_q <= pre_den;
					rem_q <= '0;
					it_q  <= '0;
					tot_q <= 1'b0;
					ret_q <= rlu_pkg::ST_POST;
				end
				rlu_pkg::ST_DIV: begin
					rem_q <= rem_n;
					num_q <= quo_n;
					it_q  <= it_q + IW'(1);
					if (div_last) res_q <= quo_n;
				end
				rlu_pkg::ST_POST: begin
					// Any division from here is by the element count.
					den_q <= RW'(cnt);
					rem_q <= '0;
					it_q  <= '0;
					ret_q <= rlu_pkg::ST_OUT;
					if (acc_on) begin
						if (last_elem) begin
							tot_q  <= 1'b1;
							res_q  <= sum_sat;
							num_q  <= sum_sat;
							acc_q  <= '0;
							seen_q <= '0;
						end else begin
							acc_q  <= sum_sat;
							seen_q <= seen_n[CW-1:0];
						end
					end else num_q <= res_q;
				end
				rlu_pkg::ST_OUT: if (out_load) begin
					tot_out_q <= tot_q;
					val_q     <= (dir_q && neg_q) ? -res_q : res_q;
				end
				default: ;
			endcase
		end
	end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for regression_loss_unit_top
// A short table of directed words, with the plainest results typed in,
// then phases of random settings and words. Other results are checked
// against a local model of the four losses, their gradients and the sum and
// mean reductions. Both sides idle at random, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint OUT_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam int COUNT_CAP = 65536;
	localparam int SETTLE = 80;
	localparam int WATCHDOG_LIMIT = 3000;

	typedef struct {
		logic signed [47:0] value;
		bit                 total;
	} loss_word_t;

	typedef struct {
		int          do_cfg;
		logic [2:0]  idx;
		int unsigned data;
		int          p;
		int          t;
		int          literal;
		longint      value;
		int          total;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] prediction = '0;
	logic signed [15:0] target = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [47:0] value;
	logic               is_total;

	// Mirror of the block's registers and running state.
	logic [1:0]  m_kind = rlu_pkg::LOSS_MSE;
	logic        m_backward = 1'b0;
	logic [1:0]  m_reduce = rlu_pkg::RED_MEAN;
	logic [15:0] m_delta = 16'd256;
	logic [16:0] m_count = 17'd1;
	longint      m_sum = 0;
	int unsigned m_seen = 0;

	loss_word_t  pending[$];
	int          errors = 0;
	bit          calm = 1'b0;
	int          idle_cycles = 0;
	int          stall_left = 0;
	int          items = 0;

	regression_loss_unit_top dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic longint unsigned count_used();
		longint unsigned c = 64'(m_count);
		if (c == 0) c = 1;
		if (c > COUNT_CAP) c = COUNT_CAP;
		return c;
	endfunction

	// Computes the result of one word, if any, and advances the running sum.
	function automatic bit loss_of_word(input logic signed [15:0] p,
			input logic signed [15:0] t, output loss_word_t w);
		longint d = longint'(p) - longint'(t);
		bit neg = d < 0;
		longint unsigned a = neg ? -d : d;
		longint unsigned dl = 64'(m_delta);
		longint unsigned cnt = count_used();
		bit mean = (m_reduce == rlu_pkg::RED_MEAN) || (m_reduce == rlu_pkg::RED_ALT);
		longint unsigned g;
		longint v;
		w.total = 1'b0;
		if (m_backward) begin
			case (m_kind)
				rlu_pkg::LOSS_MSE:    g = a << 9;
				rlu_pkg::LOSS_L1:     g = (a != 0) ? 64'd65536 : 64'd0;
				rlu_pkg::LOSS_SMOOTH:
					g = (a < dl) ? ((a << 16) / dl) : ((a != 0) ? 64'd65536 : 64'd0);
				default:     g = (a < dl) ? (a << 8) : ((a != 0) ? (dl << 8) : 64'd0);
			endcase
			if (mean) g = g / cnt;
			if (g > OUT_MAX) g = OUT_MAX;
			v = neg ? -longint'(g) : longint'(g);
			w.value = v[47:0];
			return 1'b1;
		end
		case (m_kind)
			rlu_pkg::LOSS_MSE:    g = a * a;
			rlu_pkg::LOSS_L1:     g = a << 8;
			rlu_pkg::LOSS_SMOOTH:
				g = (a < dl) ? (((a * a) << 8) / (2 * dl)) : ((a << 8) - (dl << 7));
			default:     g = (a < dl) ? ((a * a) >> 1) : ((2 * dl * a - dl * dl) >> 1);
		endcase
		if (g > OUT_MAX) g = OUT_MAX;
		if (m_reduce == rlu_pkg::RED_NONE) begin
			w.value = g[47:0];
			return 1'b1;
		end
		m_sum = m_sum + longint'(g);
		if (m_sum > OUT_MAX) m_sum = OUT_MAX;
		m_seen++;
		if (m_seen < cnt) return 1'b0;
		v = mean ? longint'(unsigned'(m_sum) / cnt) : m_sum;
		m_sum = 0;
		m_seen = 0;
		w.value = v[47:0];
		w.total = 1'b1;
		return 1'b1;
	endfunction

	// The sender pauses here until the block has drained.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int unsigned data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			rlu_pkg::REG_LOSS_KIND:     m_kind = data[1:0];
			rlu_pkg::REG_DIRECTION:     m_backward = data[0];
			rlu_pkg::REG_REDUCTION:     m_reduce = data[1:0];
			rlu_pkg::REG_DELTA:         m_delta = data[15:0];
			rlu_pkg::REG_ELEMENT_COUNT: m_count = data[16:0];
			default: ;
		endcase
	endtask

	// Sends one word; a literal expectation replaces the predicted one.
	task automatic send_word(input logic signed [15:0] p, input logic signed [15:0] t,
			input bit literal, input longint lit_value, input bit lit_total);
		loss_word_t w;
		bit has;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		prediction <= p;
		target <= t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		has = loss_of_word(p, t, w);
		if (literal) begin
			w.value = lit_value[47:0];
			w.total = lit_total;
		end
		if (has) pending.push_back(w);
		items++;
	endtask

	plan_row_t plan [23] = '{
		'{0, rlu_pkg::REG_LOSS_KIND, 0, 256, 0, 1, 65536, 1},
		'{0, rlu_pkg::REG_LOSS_KIND, 0, 32767, -32768, 1, 64'sd4294836225, 1},
		'{0, rlu_pkg::REG_LOSS_KIND, 0, -32768, 32767, 1, 64'sd4294836225, 1},
		'{0, rlu_pkg::REG_LOSS_KIND, 0, 0, 0, 1, 0, 1},
		'{1, rlu_pkg::REG_LOSS_KIND, 32'(rlu_pkg::LOSS_L1), 100, -100, 1, 51200, 1},
		'{1, rlu_pkg::REG_REDUCTION, 32'(rlu_pkg::RED_NONE), 5, 10, 1, 1280, 0},
		'{1, rlu_pkg::REG_LOSS_KIND, 32'(rlu_pkg::LOSS_SMOOTH), 300, 0, 1, 44032, 0},
		'{0, rlu_pkg::REG_LOSS_KIND, 0, 100, 0, 0, 0, 0},
		'{1, rlu_pkg::REG_DELTA, 0, 0, 0, 1, 0, 0},
		'{0, rlu_pkg::REG_LOSS_KIND, 0, 1, 0, 1, 256, 0},
		'{1, rlu_pkg::REG_LOSS_KIND, 32'(rlu_pkg::LOSS_HUBER), 3, 0, 0, 0, 0},
		'{1, rlu_pkg::REG_DELTA, 65535, 32767, -32768, 0, 0, 0},
		'{1, rlu_pkg::REG_DIRECTION, 1, -32768, 32767, 1, -16776960, 0},
		'{1, rlu_pkg::REG_LOSS_KIND, 32'(rlu_pkg::LOSS_MSE), 0, 1, 1, -512, 0},
		'{1, rlu_pkg::REG_REDUCTION, 32'(rlu_pkg::RED_ALT), 10, 3, 0, 0, 0},
		'{1, rlu_pkg::REG_ELEMENT_COUNT, 0, 7, 0, 1, 3584, 0},
		'{1, rlu_pkg::REG_ELEMENT_COUNT, 131071, 32767, -32768, 1, 511, 0},
		'{1, rlu_pkg::REG_LOSS_KIND, 32'(rlu_pkg::LOSS_L1), 0, 0, 1, 0, 0},
		'{1, rlu_pkg::REG_LOSS_KIND, 32'(rlu_pkg::LOSS_SMOOTH), 1, 0, 0, 0, 0},
		'{1, rlu_pkg::REG_ELEMENT_COUNT, 3, -5, 20, 0, 0, 0},
		'{1, rlu_pkg::REG_DIRECTION, 0, 1, 0, 0, 0, 0},
		'{0, rlu_pkg::REG_LOSS_KIND, 0, 50, 0, 0, 0, 0},
		// Lowering the count mid-tensor makes the next word close the tensor.
		'{1, rlu_pkg::REG_ELEMENT_COUNT, 2, 9, 0, 0, 0, 0}
	};

	initial begin
		int unsigned dl;
		int unsigned cnt;
		int n;
		int span;
		logic signed [15:0] p;
		logic signed [15:0] t;
		@(posedge arst_n);
		repeat (SETTLE) @(posedge clk);
		foreach (plan[i]) begin
			if (plan[i].do_cfg != 0) begin
				wait_drained();
				write_reg(plan[i].idx, plan[i].data);
			end
			send_word(16'(plan[i].p), 16'(plan[i].t), plan[i].literal != 0,
				plan[i].value, plan[i].total != 0);
		end
		while (items < 440) begin
			if (items > 360) calm = 1'b1;
			wait_drained();
			write_reg(rlu_pkg::REG_LOSS_KIND, $urandom_range(0, 3));
			write_reg(rlu_pkg::REG_DIRECTION, $urandom_range(0, 1));
			write_reg(rlu_pkg::REG_REDUCTION, $urandom_range(0, 3));
			case ($urandom_range(0, 4))
				0: dl = 0;
				1: dl = 1;
				2: dl = 65535;
				3: dl = $urandom_range(1, 1024);
				default: dl = $urandom_range(0, 65535);
			endcase
			write_reg(rlu_pkg::REG_DELTA, dl);
			if (!m_backward && m_reduce != rlu_pkg::RED_NONE) cnt = $urandom_range(0, 6);
			else if ($urandom_range(0, 1)) cnt = $urandom_range(0, 131071);
			else cnt = $urandom_range(1, 9);
			write_reg(rlu_pkg::REG_ELEMENT_COUNT, cnt);
			if (!m_backward && m_reduce != rlu_pkg::RED_NONE)
				n = int'(count_used()) * int'($urandom_range(2, 6));
			else n = int'($urandom_range(10, 30));
			span = int'(2 * dl + 4);
			repeat (n) begin
				p = 16'($urandom);
				if ($urandom_range(0, 1)) t = 16'($urandom);
				else if ($urandom_range(0, 1)) t = p + 16'($urandom_range(0, span));
				else t = p - 16'($urandom_range(0, span));
				send_word(p, t, 1'b0, 0, 1'b0);
			end
		end
		wait_drained();
		if (errors == 0) begin
			$display("PASS regression_loss_unit_top");
		end else begin
			$display("FAIL regression_loss_unit_top");
		end
		$finish;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= int'($urandom_range(0, 8));
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		loss_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				$error("unexpected word: value %0d is_total %0b", value, is_total);
				errors++;
			end else begin
				w = pending.pop_front();
				if (value !== w.value) begin
					$error("value: expected %0d, got %0d", w.value, value);
					errors++;
				end
				if (is_total !== w.total) begin
					$error("is_total: expected %0b, got %0b", w.total, is_total);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL regression_loss_unit_top");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule
